/* rtl/fcdt_pkg.sv */
// Shared types for the frame call depth tracker.
// Item structs for the request and result sides; no dependencies.
`timescale 1ns / 1ps

package fcdt_pkg;

  // Fixed field widths of one item on each side
  localparam int unsigned FrameFieldW = 32;
  localparam int unsigned LevelFieldW = 8;

  // One intercepted call
  typedef struct packed {
    logic [FrameFieldW-1:0] caller_frame;
    logic [FrameFieldW-1:0] callee_frame;
  } fcdt_req_t;

  // One depth result
  typedef struct packed {
    logic [LevelFieldW-1:0] depth_level;
    logic                   depth_overflow;
  } fcdt_res_t;

endpackage

/* rtl/fcdt_frame_mem.sv */
// Frame store: one write port and one read port, registered read data.
// Depends on nothing; sized by the stack depth and frame width parameters.
`timescale 1ns / 1ps

module fcdt_frame_mem #(
  parameter int unsigned STACK_DEPTH = 256,
  parameter int unsigned FRAME_BITS  = 32,
  localparam int unsigned IdxW = $clog2(STACK_DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [IdxW-1:0]       waddr_i,
  input  logic [FRAME_BITS-1:0] wdata_i,
  input  logic                  re_i,
  input  logic [IdxW-1:0]       raddr_i,
  output logic [FRAME_BITS-1:0] rdata_o
);

  logic [FRAME_BITS-1:0] mem_q [STACK_DEPTH];
  logic [FRAME_BITS-1:0] rdata_q;

  // Write the callee frame at the new level
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read one entry, data appears the next cycle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/fcdt_search_ctrl.sv */
// Search sequencer: walks the frame store from the top entry downwards.
// Depends on fcdt_pkg for the item structs; drives the frame store ports.
`timescale 1ns / 1ps

module fcdt_search_ctrl
  import fcdt_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 256,
  parameter int unsigned FRAME_BITS  = 32,
  localparam int unsigned IdxW = $clog2(STACK_DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  fcdt_req_t             req_i,
  output logic                  busy_o,
  output logic                  res_valid_o,
  output fcdt_res_t             res_o,
  output logic                  mem_we_o,
  output logic [IdxW-1:0]       mem_waddr_o,
  output logic [FRAME_BITS-1:0] mem_wdata_o,
  output logic                  mem_re_o,
  output logic [IdxW-1:0]       mem_raddr_o,
  input  logic [FRAME_BITS-1:0] mem_rdata_i
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(STACK_DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SEARCH = 2'b10
  } fcdt_state_e;

  fcdt_state_e           state_q, state_d;
  logic [IdxW-1:0]       top_q, top_d;
  logic                  empty_q, empty_d;
  logic [IdxW-1:0]       cmp_idx_q, cmp_idx_d;
  logic [FRAME_BITS-1:0] caller_q, caller_d;
  logic [FRAME_BITS-1:0] callee_q, callee_d;
  logic [IdxW-1:0]       level;
  logic                  overflow;
  logic                  finish;
  logic                  hit;

  assign hit = (mem_rdata_i == caller_q);

  // Sequence one item: issue a read per cycle, compare the entry read last cycle
  always_comb begin
    state_d     = state_q;
    top_d       = top_q;
    empty_d     = empty_q;
    cmp_idx_d   = cmp_idx_q;
    caller_d    = caller_q;
    callee_d    = callee_q;
    level       = '0;
    overflow    = 1'b0;
    finish      = 1'b0;
    mem_we_o    = 1'b0;
    mem_wdata_o = callee_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = cmp_idx_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          caller_d = FRAME_BITS'(req_i.caller_frame);
          callee_d = FRAME_BITS'(req_i.callee_frame);
          if (empty_q) begin
            // Empty stack: no search, place the frame at level zero
            finish      = 1'b1;
            mem_wdata_o = FRAME_BITS'(req_i.callee_frame);
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = top_q;
            cmp_idx_d   = top_q;
            state_d     = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          finish = 1'b1;
          if (cmp_idx_q == LastIdx) begin
            // Saturate at the deepest entry
            level    = LastIdx;
            overflow = 1'b1;
          end else begin
            level = cmp_idx_q + 1'b1;
          end
        end else if (cmp_idx_q == '0) begin
          // Nothing matched: outermost level
          finish = 1'b1;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = cmp_idx_q - 1'b1;
          cmp_idx_d   = cmp_idx_q - 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Commit: write the callee frame, move the top, drop back to idle
    if (finish) begin
      mem_we_o = 1'b1;
      top_d    = level;
      empty_d  = 1'b0;
      state_d  = ST_IDLE;
    end
  end

  assign mem_waddr_o          = level;
  assign busy_o               = (state_q != ST_IDLE);
  assign res_valid_o          = finish;
  assign res_o.depth_level    = LevelFieldW'(level);
  assign res_o.depth_overflow = overflow;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      top_q   <= '0;
      empty_q <= 1'b1;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      empty_q <= empty_d;
    end
  end

  // Item payload and search pointer carry no reset
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    caller_q  <= caller_d;
    callee_q  <= callee_d;
  end

endmodule

/* rtl/frame_call_depth_tracker.sv */
// Channel   | Ports                    | Handshake
// ----------+--------------------------+-------------------------------------
// request   | start, busy, req_i       | taken when start is high, busy low
// result    | done_o, res_o            | one-cycle strobe, cannot be held off
//
// An item on an empty stack gives its result the cycle after it is taken.
// Otherwise the search reads one stored frame per cycle from the top entry
// down with busy high, until a match or entry zero, and the result strobes
// in the same cycle that busy falls.
// Reset empties the stack; stored frames need no clearing.
// Top level: depends on fcdt_pkg, fcdt_search_ctrl and fcdt_frame_mem.
`timescale 1ns / 1ps

module frame_call_depth_tracker
  import fcdt_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 256,
  parameter int unsigned FRAME_BITS  = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  fcdt_req_t req_i,
  output logic      done_o,
  output fcdt_res_t res_o
);

  localparam int unsigned IdxW = $clog2(STACK_DEPTH);

  logic                  mem_we;
  logic [IdxW-1:0]       mem_waddr;
  logic [FRAME_BITS-1:0] mem_wdata;
  logic                  mem_re;
  logic [IdxW-1:0]       mem_raddr;
  logic [FRAME_BITS-1:0] mem_rdata;
  logic                  res_valid;
  fcdt_res_t             res;
  logic                  done_q;
  fcdt_res_t             res_q;

  fcdt_search_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .FRAME_BITS  (FRAME_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req_i),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  fcdt_frame_mem #(
    .STACK_DEPTH (STACK_DEPTH),
    .FRAME_BITS  (FRAME_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Register the result strobe, and hold the result until the next one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* dv/frame_call_depth_tracker_tb.sv */
// Self-checking bench for frame_call_depth_tracker: call chains, returns and
// stray calls go in through the start/busy port; each depth strobe is checked.
// Depends on fcdt_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module frame_call_depth_tracker_tb;
  import fcdt_pkg::*;

  localparam int unsigned StackDepth = 256;
  localparam int unsigned FrameBits  = 32;
  localparam int unsigned CallTarget = 1300;
  localparam int unsigned CycleLimit = 1200000;
  // Longest search is a full stack walk plus the result strobe
  localparam int unsigned DrainWait  = StackDepth + 40;

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start  = 1'b0;
  logic      busy;
  fcdt_req_t req_i  = '0;
  logic      done_o;
  fcdt_res_t res_o;

  frame_call_depth_tracker #(
    .STACK_DEPTH (StackDepth),
    .FRAME_BITS  (FrameBits)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Calls waiting to be driven, and depths owed by the block in order
  fcdt_req_t   pending_calls[$];
  fcdt_res_t   depths_due[$];
  logic [31:0] callee_log[$];

  // Shadow of the frame stack
  logic [FrameBits-1:0] shadow_frames[StackDepth];
  int unsigned          shadow_top    = 0;
  bit                   shadow_vacant = 1'b1;

  int unsigned calls_taken    = 0;
  int unsigned depths_checked = 0;
  int unsigned overflow_seen  = 0;
  int unsigned unmatched_seen = 0;
  int unsigned deepest_seen   = 0;
  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;
  int unsigned idle_left      = 0;

  // Search the shadow stack from the top down and push the callee frame
  function automatic fcdt_res_t predict_depth(fcdt_req_t call);
    logic [FrameBits-1:0] caller;
    int unsigned          idx;
    int unsigned          lvl;
    bit                   ovf;
    bit                   hit;
    fcdt_res_t            res;
    caller = call.caller_frame;
    lvl    = 0;
    ovf    = 1'b0;
    hit    = 1'b0;
    if (!shadow_vacant) begin
      idx = shadow_top;
      while (!hit) begin
        if (shadow_frames[idx] == caller) begin
          hit = 1'b1;
          if (idx + 1 >= StackDepth) begin
            lvl = StackDepth - 1;
            ovf = 1'b1;
          end else begin
            lvl = idx + 1;
          end
        end else if (idx == 0) begin
          break;
        end else begin
          idx--;
        end
      end
      if (!hit) unmatched_seen++;
    end
    shadow_frames[lvl] = call.callee_frame;
    shadow_top         = lvl;
    shadow_vacant      = 1'b0;
    res.depth_level    = lvl[LevelFieldW-1:0];
    res.depth_overflow = ovf;
    return res;
  endfunction

  // Queue one call and remember its callee for later returns
  task automatic add_call(input logic [31:0] caller, input logic [31:0] callee);
    fcdt_req_t call;
    call.caller_frame = caller;
    call.callee_frame = callee;
    pending_calls.push_back(call);
    callee_log.push_back(callee);
  endtask

  // Mostly wide random frames, some near the extremes so values repeat
  function automatic logic [31:0] draw_frame();
    logic [31:0] f;
    case ($urandom_range(0, 9))
      0:       f = $urandom_range(0, 3);
      1:       f = 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: f = $urandom;
    endcase
    return f;
  endfunction

  // Pick a callee from the recent past, or from anywhere when far is set
  function automatic logic [31:0] past_callee(input bit far);
    int unsigned n;
    int unsigned back;
    n = callee_log.size();
    back = far ? $urandom_range(0, n - 1) : $urandom_range(0, (n > 40) ? 40 : n - 1);
    return callee_log[n - 1 - back];
  endfunction

  // Build a chain of nested calls, each from the frame entered last
  task automatic add_chain(input int unsigned len);
    for (int unsigned k = 0; k < len; k++) begin
      add_call(callee_log[callee_log.size() - 1], draw_frame());
    end
  endtask

  // Drive calls; record the expected depth at the edge a call is taken
  always @(posedge clk_i or negedge rst_ni) begin
    fcdt_req_t next_call;
    if (!rst_ni) begin
      start     <= 1'b0;
      req_i     <= '0;
      idle_left = 0;
    end else begin
      if (start && !busy) begin
        depths_due.push_back(predict_depth(req_i));
        calls_taken++;
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pending_calls.size() > 0) begin
        next_call = pending_calls.pop_front();
        req_i     <= next_call;
        start     <= 1'b1;
        // Hold no gaps for one stretch in three
        idle_left = ((calls_taken / 64) % 3 == 1) ? 0 : $urandom_range(0, 8);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Check every depth strobe against the oldest expectation
  always @(posedge clk_i) begin
    fcdt_res_t want;
    if (rst_ni && done_o) begin
      if (depths_due.size() == 0) begin
        $error("depth result with no call outstanding: level %0d overflow %0b",
               res_o.depth_level, res_o.depth_overflow);
        fail_count++;
      end else begin
        want = depths_due.pop_front();
        depths_checked++;
        if (res_o.depth_level !== want.depth_level) begin
          $error("depth_level: expected %0d, got %0d", want.depth_level, res_o.depth_level);
          fail_count++;
        end
        if (res_o.depth_overflow !== want.depth_overflow) begin
          $error("depth_overflow: expected %0b, got %0b",
                 want.depth_overflow, res_o.depth_overflow);
          fail_count++;
        end
        if (want.depth_overflow) overflow_seen++;
        if (want.depth_level > deepest_seen) deepest_seen = want.depth_level;
      end
    end
  end

  // Abandon a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("frame_call_depth_tracker verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    int unsigned len;
    bit          deep_done_a;
    bit          deep_done_b;
    deep_done_a = 1'b0;
    deep_done_b = 1'b0;

    // Directed: empty stack, extreme frames, returns, stale entries, repeats
    add_call(32'h0000_0000, 32'hFFFF_FFFF);
    add_call(32'hFFFF_FFFF, 32'h0000_0000);
    add_call(32'h0000_0000, 32'hAAAA_AAAA);
    add_call(32'hAAAA_AAAA, 32'h5555_5555);
    add_call(32'hFFFF_FFFF, 32'h1234_5678);
    add_call(32'h5555_5555, 32'h0000_0001);
    add_call(32'h0000_0001, 32'h0000_0001);
    add_call(32'h0000_0001, 32'h0000_0001);
    add_call(32'h0000_0001, 32'h0000_0007);
    add_call(32'hDEAD_BEEF, 32'h0000_0000);
    add_call(32'h0000_0000, 32'h8000_0000);
    add_call(32'h8000_0000, 32'h7FFF_FFFF);
    add_call(32'h0000_0001, 32'hFFFF_FFFE);

    // Random: mostly call chains and returns, some stray callers
    while (pending_calls.size() < CallTarget) begin
      // Twice, walk a chain past the deepest entry, then unwind into it
      if ((!deep_done_a && pending_calls.size() > 350) ||
          (!deep_done_b && pending_calls.size() > 850)) begin
        if (deep_done_a) deep_done_b = 1'b1;
        deep_done_a = 1'b1;
        add_chain(StackDepth + $urandom_range(2, 8));
        add_call(past_callee(1'b0), draw_frame());
        add_call(draw_frame(), draw_frame());
      end
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
        add_chain($urandom_range(1, 20));
      end else if (pick <= 5) begin
        len = $urandom_range(1, 5);
        repeat (len) add_call(past_callee(1'b0), draw_frame());
      end else if (pick == 6) begin
        add_call(past_callee(1'b1), draw_frame());
      end else begin
        len = $urandom_range(1, 3);
        repeat (len) add_call(draw_frame(), draw_frame());
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every call taken, every depth seen, then let the block settle
    while (pending_calls.size() > 0 || start) @(posedge clk_i);
    while (depths_due.size() > 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (depths_due.size() > 0) begin
      $error("%0d depth results never arrived", depths_due.size());
      fail_count++;
    end
    $display("Checked %0d depths over %0d calls: %0d unmatched callers, %0d overflows,",
             depths_checked, calls_taken, unmatched_seen, overflow_seen);
    $display("deepest level reached %0d, %0d cycles.", deepest_seen, cycle_count);
    if (fail_count == 0) begin
      $display("frame_call_depth_tracker verification clean");
    end else begin
      $display("frame_call_depth_tracker verification failed");
    end
    $finish;
  end

endmodule
